[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, held off while reset is asserted
`define MSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// concurrent check, live during reset too
`define MSE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

[hw/rtl/mse_pkg.sv]
// Types and constants of the mean and standard error block
`timescale 1ns / 1ps
package mse_pkg;
  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned CountW     = 13;
  localparam int unsigned SumW       = 28;
  localparam int unsigned SqSumW     = 43;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned MeanW      = 24;
  localparam int unsigned ErrW       = 30;
  localparam int unsigned BoundW     = 32;
  localparam int unsigned NumW       = 84;
  localparam int unsigned DenW       = 37;
  localparam int unsigned MulW       = 72;
  localparam int unsigned MulBW      = 28;
  localparam int unsigned RadW       = 60;
  localparam int unsigned StepW      = 7;

  typedef struct packed {
    logic [CountW-1:0]        count;
    logic signed [SumW-1:0]   sum;
    logic [SqSumW-1:0]        sq_sum;
    logic                     mode;
  } job_t;

  typedef struct packed {
    logic signed [MeanW-1:0]  mean;
    logic [ErrW-1:0]          error;
    logic signed [BoundW-1:0] upper_bound;
    logic signed [BoundW-1:0] lower_bound;
    logic                     status;
  } res_t;
endpackage

[hw/rtl/mse_front.sv]
// Front part: accumulates samples and issues one job per set
`timescale 1ns / 1ps
module mse_front import mse_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      last_sample_i,
  input  logic                      mode_i,
  output logic                      job_push_o,
  output job_t                      job_o
);
  logic [CountW-1:0]      count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SqSumW-1:0]      sq_q, sq_d;
  logic signed [31:0]     prod;
  logic                   room;

  always_comb begin
    prod    = 32'(sample_i) * 32'(sample_i);
    room    = count_q < CountW'(MaxSamples);
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    if (room) begin
      count_d = count_q + CountW'(1);
      sum_d   = sum_q + SumW'(sample_i);
      sq_d    = sq_q + SqSumW'(unsigned'(prod[30:0]));
    end
  end

  assign job_push_o   = accept_i && last_sample_i;
  assign job_o.count  = count_d;
  assign job_o.sum    = sum_d;
  assign job_o.sq_sum = sq_d;
  assign job_o.mode   = mode_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else if (accept_i) begin
      if (last_sample_i) begin
        count_q <= '0;
        sum_q   <= '0;
        sq_q    <= '0;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        sq_q    <= sq_d;
      end
    end
  end
endmodule

[hw/rtl/mse_queue.sv]
// Two-entry job queue between the front and back parts
`timescale 1ns / 1ps
module mse_queue import mse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);
  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

[hw/rtl/mse_back.sv]
// Back part: serial divide, multiply and square root per job
`timescale 1ns / 1ps
module mse_back import mse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  input  logic res_pop_i,
  output logic res_valid_o,
  output res_t res_o
);
  typedef enum logic [3:0] {
    B_IDLE, B_MEAN, B_MNQ, B_MSS, B_MN2, B_MK, B_DIV, B_SQRT, B_FIN
  } state_e;

  state_e             state_q;
  logic [CountW-1:0]  n_q;
  logic               neg_q, mode_q, low_q;
  logic [SumW-1:0]    abs_q;
  logic [SqSumW-1:0]  sq_q;
  logic [55:0]        p_q, m_q;
  logic [24:0]        n2_q;
  logic [MeanW-1:0]   mean_q;
  logic [ErrW-1:0]    err_q;
  logic [MulW-1:0]    mul_a_q, acc_q, mul_sum;
  logic [MulBW-1:0]   mul_b_q;
  logic [NumW-1:0]    num_q, div_num;
  logic [DenW-1:0]    den_q;
  logic [DenW:0]      rem_q, div_rem;
  logic [DenW+1:0]    rem_sh;
  logic               div_ge;
  logic [RadW-1:0]    rad_q;
  logic [ErrW-1:0]    root_q, root_d;
  logic [31:0]        srem_q, srem_sh, trial, srem_d;
  logic               sq_ge;
  logic [StepW-1:0]   cnt_q;
  logic               last_step;
  logic [MeanW-1:0]   mean_val;
  logic [11:0]        k;
  logic               res_valid_q;
  res_t               res_q;
  logic [SumW-1:0]    abs_in;

  assign job_pop_o   = (state_q == B_IDLE) && job_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign last_step   = cnt_q == '0;
  assign k           = 12'(n_q - CountW'(1));
  assign abs_in      = job_i.sum[SumW-1] ? SumW'(-job_i.sum) : job_i.sum;

  always_comb begin
    mul_sum = acc_q + (mul_b_q[0] ? mul_a_q : '0);
    rem_sh  = {rem_q, num_q[NumW-1]};
    div_ge  = rem_sh >= {2'b00, den_q};
    div_rem = div_ge ? (DenW+1)'(rem_sh - {2'b00, den_q}) : rem_sh[DenW:0];
    div_num = {num_q[NumW-2:0], div_ge};
    srem_sh = {srem_q[29:0], rad_q[RadW-1:RadW-2]};
    trial   = {root_q, 2'b01};
    sq_ge   = srem_sh >= trial;
    srem_d  = sq_ge ? srem_sh - trial : srem_sh;
    root_d  = {root_q[ErrW-2:0], sq_ge};
    if (n_q == '0) begin
      mean_val = '0;
    end else if (neg_q) begin
      mean_val = MeanW'(-(div_num[MeanW-1:0] + MeanW'(div_rem != '0)));
    end else begin
      mean_val = div_num[MeanW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (res_pop_i && res_valid_q) res_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            n_q    <= job_i.count;
            neg_q  <= job_i.sum[SumW-1];
            abs_q  <= abs_in;
            sq_q   <= job_i.sq_sum;
            mode_q <= job_i.mode;
            low_q  <= (job_i.count == '0) || (!job_i.mode && job_i.count < CountW'(2));
            num_q  <= NumW'({abs_in, 8'h00});
            den_q  <= DenW'(job_i.count);
            rem_q  <= '0;
            cnt_q  <= StepW'(NumW - 1);
            state_q <= B_MEAN;
          end
        end
        B_MEAN: begin
          num_q <= div_num;
          rem_q <= div_rem;
          cnt_q <= cnt_q - StepW'(1);
          if (last_step) begin
            mean_q <= mean_val;
            if (low_q) begin
              err_q   <= '0;
              state_q <= B_FIN;
            end else begin
              mul_a_q <= MulW'(sq_q);
              mul_b_q <= MulBW'(n_q);
              acc_q   <= '0;
              cnt_q   <= StepW'(MulBW - 1);
              state_q <= B_MNQ;
            end
          end
        end
        B_MNQ, B_MSS, B_MN2, B_MK: begin
          acc_q   <= mul_sum;
          mul_a_q <= {mul_a_q[MulW-2:0], 1'b0};
          mul_b_q <= {1'b0, mul_b_q[MulBW-1:1]};
          cnt_q   <= cnt_q - StepW'(1);
          if (last_step) begin
            acc_q <= '0;
            cnt_q <= StepW'(MulBW - 1);
            unique case (state_q)
              B_MNQ: begin
                p_q     <= mul_sum[55:0];
                mul_a_q <= MulW'(abs_q);
                mul_b_q <= abs_q;
                state_q <= B_MSS;
              end
              B_MSS: begin
                m_q     <= p_q - mul_sum[55:0];
                mul_a_q <= MulW'(n_q);
                mul_b_q <= MulBW'(n_q);
                state_q <= B_MN2;
              end
              B_MN2: begin
                n2_q    <= mul_sum[24:0];
                mul_a_q <= mode_q ? MulW'(m_q) : MulW'(mul_sum[24:0]);
                mul_b_q <= MulBW'(k);
                state_q <= B_MK;
              end
              default: begin
                if (mode_q) begin
                  num_q <= {mul_sum[67:0], 16'h0000};
                  den_q <= DenW'(n2_q);
                end else begin
                  num_q <= {13'b0, m_q[54:0], 16'h0000};
                  den_q <= mul_sum[DenW-1:0];
                end
                rem_q   <= '0;
                cnt_q   <= StepW'(NumW - 1);
                state_q <= B_DIV;
              end
            endcase
          end
        end
        B_DIV: begin
          num_q <= div_num;
          rem_q <= div_rem;
          cnt_q <= cnt_q - StepW'(1);
          if (last_step) begin
            rad_q   <= div_num[RadW-1:0];
            root_q  <= '0;
            srem_q  <= '0;
            cnt_q   <= StepW'(ErrW - 1);
            state_q <= B_SQRT;
          end
        end
        B_SQRT: begin
          rad_q  <= {rad_q[RadW-3:0], 2'b00};
          root_q <= root_d;
          srem_q <= srem_d;
          cnt_q  <= cnt_q - StepW'(1);
          if (last_step) begin
            err_q   <= root_d;
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          if (!res_valid_q || res_pop_i) begin
            res_q.mean        <= mean_q;
            res_q.error       <= err_q;
            res_q.upper_bound <= BoundW'(signed'(mean_q)) + BoundW'(err_q);
            res_q.lower_bound <= BoundW'(signed'(mean_q)) - BoundW'(err_q);
            res_q.status      <= low_q;
            res_valid_q       <= 1'b1;
            state_q           <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/mean_and_standard_error_top.sv]
// Top level of the mean and standard error block
// Samples are taken one per cycle while full is low and summed in the front part; the
// item marked last hands the count and sums to a two-entry job queue. The back part
// works one set at a time with a one-bit-per-cycle divider, shift-add multiplier and
// square root: a mean divide, four multiplies, a divide and a root per set, or only the
// mean divide for a set flagged too small; a result left unpopped holds the back part.
// full is raised while both queue entries wait, and no sample is taken then.
`timescale 1ns / 1ps
module mean_and_standard_error_top import mse_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     push,
  output logic                     full,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                     last_sample_i,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [MeanW-1:0]  mean_o,
  output logic [ErrW-1:0]          error_o,
  output logic signed [BoundW-1:0] upper_bound_o,
  output logic signed [BoundW-1:0] lower_bound_o,
  output logic                     status_o
);
`include "assert_macros.svh"

  logic error_mode_q;
  logic accept, job_push, job_valid, job_pop, res_valid;
  job_t job_in, job_out;
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, error_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      error_mode_q <= pwdata[0];
    end
  end

  assign accept = push && !full;

  mse_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .sample_i,
    .last_sample_i,
    .mode_i        (error_mode_q),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  mse_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  mse_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty         = !res_valid;
  assign mean_o        = res.mean;
  assign error_o       = res.error;
  assign upper_bound_o = res.upper_bound;
  assign lower_bound_o = res.lower_bound;
  assign status_o      = res.status;

  `MSE_ASSERT(a_low_no_err, !empty && status_o |-> error_o == '0)
  `MSE_ASSERT(a_low_bounds, !empty && status_o |-> upper_bound_o == lower_bound_o)
  `MSE_ASSERT(a_upper, !empty |-> upper_bound_o == BoundW'(mean_o) + BoundW'(error_o))
endmodule
